// ===== rtl/core/tklst_pkg.sv =====
// Shared types and codes for the top-K ranked list core.
// Used by the controller, the datapath and the top level; depends on nothing.
package tklst_pkg;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic compare;  // register per-entry compare flags
    logic update;   // apply the item to the list and register the result
  } dp_cmd_t;

endpackage

// ===== rtl/core/tklst_ctrl.sv =====
// Sequencer for the top-K ranked list: load, compare, update, result strobe.
// Depends on tklst_pkg for the datapath command struct.
module tklst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              result_strobe_o,
  output tklst_pkg::dp_cmd_t cmd_o
);
  import tklst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   strobe_q;

  // Commands follow the state directly
  assign cmd_o.load    = (state_q == ST_IDLE) && start;
  assign cmd_o.compare = (state_q == ST_CMP);
  assign cmd_o.update  = (state_q == ST_UPD);

  assign busy            = busy_q;
  assign result_strobe_o = strobe_q;

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CMP;
            busy_q  <= 1'b1;
          end
        end
        ST_CMP: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          state_q  <= ST_IDLE;
          busy_q   <= 1'b0;
          strobe_q <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tklst_dpath.sv =====
// Datapath of the top-K ranked list: a row of sorted entry cells with
// per-cell compare, insert-and-shift, rank read and result registers.
// Depends on tklst_pkg for operation codes and the command struct.
module tklst_dpath #(
  parameter int MAX_ENTRIES  = 16,
  parameter int FITNESS_BITS = 32,
  parameter int ID_BITS      = 16,
  localparam int IdxW = $clog2(MAX_ENTRIES),
  localparam int CntW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tklst_pkg::dp_cmd_t      cmd_i,
  input  logic [1:0]              operation_i,
  input  logic [FITNESS_BITS-1:0] fitness_value_i,
  input  logic [ID_BITS-1:0]      agent_id_i,
  input  logic [IdxW-1:0]         read_rank_i,
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         capacity_in_use_i,
  output logic                    accepted_o,
  output logic [IdxW-1:0]         insert_rank_o,
  output logic [FITNESS_BITS-1:0] entry_fitness_o,
  output logic [ID_BITS-1:0]      entry_id_o,
  output logic                    rank_invalid_o,
  output logic [CntW-1:0]         entry_count_o,
  output logic                    list_full_o
);
  import tklst_pkg::*;

  // Captured item
  logic [1:0]              op_q;
  logic [FITNESS_BITS-1:0] fit_q;
  logic [ID_BITS-1:0]      id_q;
  logic [IdxW-1:0]         rrank_q;

  // Entry cells, sorted from fittest to weakest
  logic [FITNESS_BITS-1:0] cell_fit_q [MAX_ENTRIES];
  logic [ID_BITS-1:0]      cell_id_q  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  gt_d, gt_q;

  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] cap_q, cap_wr;

  logic            full;
  logic            offer_ok;
  logic            do_insert;
  logic [CntW-1:0] rank_enc;
  logic            rd_ok;

  // Capacity write value: zero means one, above the depth saturates
  always_comb begin
    if (capacity_in_use_i == '0) begin
      cap_wr = CntW'(1);
    end else if (capacity_in_use_i > CntW'(MAX_ENTRIES)) begin
      cap_wr = CntW'(MAX_ENTRIES);
    end else begin
      cap_wr = capacity_in_use_i;
    end
  end

  // Per-cell compare: candidate strictly beats a held entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gt_d[i] = (CntW'(i) < held_q) && (fit_q > cell_fit_q[i]);
    end
  end

  // Insert rank: first beaten entry, else the end of the list
  always_comb begin
    rank_enc = held_q;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (gt_q[i]) rank_enc = CntW'(i);
    end
  end

  // List is sorted, so beating any entry means beating the last one
  assign full      = (held_q >= cap_q);
  assign offer_ok  = !full || (|gt_q);
  assign do_insert = cmd_i.update && (op_q == OP_OFFER) && offer_ok;
  assign rd_ok     = (CntW'(rrank_q) < held_q);

  // Count after this item
  always_comb begin
    held_d = held_q;
    case (op_q)
      OP_OFFER: if (offer_ok && !full) held_d = held_q + CntW'(1);
      OP_CLEAR: held_d = '0;
      default:  held_d = held_q;
    endcase
  end

  // Item capture and compare flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      fit_q   <= fitness_value_i;
      id_q    <= agent_id_i;
      rrank_q <= read_rank_i;
    end
    if (cmd_i.compare) begin
      gt_q <= gt_d;
    end
  end

  // Cells: write at the insert rank, shift the weaker ones down one place
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (do_insert) begin
        if (CntW'(i) == rank_enc) begin
          cell_fit_q[i] <= fit_q;
          cell_id_q[i]  <= id_q;
        end else if (i > 0 && CntW'(i) > rank_enc) begin
          cell_fit_q[i] <= cell_fit_q[(i > 0) ? i - 1 : 0];
          cell_id_q[i]  <= cell_id_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cap_q  <= CntW'(MAX_ENTRIES);
    end else if (cmd_i.update) begin
      held_q <= held_d;
    end else if (cfg_we_i) begin
      cap_q <= cap_wr;
      if (held_q > cap_wr) held_q <= cap_wr;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      accepted_o      <= 1'b0;
      insert_rank_o   <= '0;
      entry_fitness_o <= '0;
      entry_id_o      <= '0;
      rank_invalid_o  <= 1'b0;
      entry_count_o   <= held_d;
      list_full_o     <= (held_d == cap_q);
      case (op_q)
        OP_OFFER: begin
          if (offer_ok) begin
            accepted_o    <= 1'b1;
            insert_rank_o <= rank_enc[IdxW-1:0];
          end
        end
        OP_READ: begin
          if (rd_ok) begin
            entry_fitness_o <= cell_fit_q[rrank_q];
            entry_id_o      <= cell_id_q[rrank_q];
          end else begin
            rank_invalid_o <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/top_k_ranked_list_core.sv =====
// Top-K ranked list: an accepted item passes through the compare and update
// states over the entry cells before the result strobe; no new item is taken
// while busy, and the next item is taken in the strobe cycle.
// Results cannot be stalled. Async active-low reset empties the list and
// sets the capacity to MAX_ENTRIES; entry contents are not cleared.
module top_k_ranked_list_core #(
  parameter int MAX_ENTRIES  = 16,
  parameter int FITNESS_BITS = 32,
  parameter int ID_BITS      = 16,
  localparam int IdxW = $clog2(MAX_ENTRIES),
  localparam int CntW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    result_strobe_o,
  input  logic [1:0]              operation_i,
  input  logic [FITNESS_BITS-1:0] fitness_value_i,
  input  logic [ID_BITS-1:0]      agent_id_i,
  input  logic [IdxW-1:0]         read_rank_i,
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         capacity_in_use_i,
  output logic                    accepted_o,
  output logic [IdxW-1:0]         insert_rank_o,
  output logic [FITNESS_BITS-1:0] entry_fitness_o,
  output logic [ID_BITS-1:0]      entry_id_o,
  output logic                    rank_invalid_o,
  output logic [CntW-1:0]         entry_count_o,
  output logic                    list_full_o
);
  import tklst_pkg::*;

  dp_cmd_t cmd;

  // Sequencer
  tklst_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .result_strobe_o (result_strobe_o),
    .cmd_o           (cmd)
  );

  // Entry cells and result registers
  tklst_dpath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .FITNESS_BITS (FITNESS_BITS),
    .ID_BITS      (ID_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .operation_i       (operation_i),
    .fitness_value_i   (fitness_value_i),
    .agent_id_i        (agent_id_i),
    .read_rank_i       (read_rank_i),
    .cfg_we_i          (cfg_we_i),
    .capacity_in_use_i (capacity_in_use_i),
    .accepted_o        (accepted_o),
    .insert_rank_o     (insert_rank_o),
    .entry_fitness_o   (entry_fitness_o),
    .entry_id_o        (entry_id_o),
    .rank_invalid_o    (rank_invalid_o),
    .entry_count_o     (entry_count_o),
    .list_full_o       (list_full_o)
  );

endmodule

// ===== rtl/core/tklst_checker.sv =====
// Port-level checks for the top-K ranked list core, attached by bind.
// Depends only on the top level's ports and parameters.
module tklst_checker #(
  parameter int FITNESS_BITS = 32,
  parameter int ID_BITS      = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    result_strobe_o,
  input logic                    accepted_o,
  input logic                    rank_invalid_o,
  input logic [FITNESS_BITS-1:0] entry_fitness_o,
  input logic [ID_BITS-1:0]      entry_id_o
);

  // Every accepted item yields its result strobe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_strobe_o)
    else $error("result strobe missing after accepted item");

  // No result without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(start && !busy, 3))
    else $error("result strobe without accepted item");

  // Core is free again when the result shows
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("busy while result is shown");

  // A bad rank read returns a zero entry and no insert
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && rank_invalid_o) |->
      (entry_fitness_o == '0 && entry_id_o == '0 && !accepted_o))
    else $error("invalid rank read carries data");

endmodule

bind top_k_ranked_list_core tklst_checker #(
  .FITNESS_BITS (FITNESS_BITS),
  .ID_BITS      (ID_BITS)
) u_tklst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .accepted_o      (accepted_o),
  .rank_invalid_o  (rank_invalid_o),
  .entry_fitness_o (entry_fitness_o),
  .entry_id_o      (entry_id_o)
);

// ===== bench/testbench.sv =====
// Self-checking bench for top_k_ranked_list_core: directed table, then random phases,
// each item checked against a behavioral list model kept here, or its pinned result.
// Depends on tklst_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tklst_pkg::*;

  localparam int MaxEntries = 16;
  localparam int PlanLen    = 27;
  localparam int MaxGap     = 13;
  localparam logic [1:0] OpUnused = 2'd3;

  // One result item as seen on the output ports
  typedef struct packed {
    logic        accepted;
    logic [3:0]  insert_rank;
    logic [31:0] entry_fitness;
    logic [15:0] entry_id;
    logic        rank_invalid;
    logic [4:0]  entry_count;
    logic        list_full;
  } outcome_t;

  // One row of the directed table: either a capacity write or an item
  typedef struct packed {
    logic        cfg_write;
    logic [1:0]  op;
    logic [31:0] fit;
    logic [15:0] id;
    logic [3:0]  rank;
    logic        pinned;
    outcome_t    want;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        result_strobe_o;
  logic [1:0]  operation_i;
  logic [31:0] fitness_value_i;
  logic [15:0] agent_id_i;
  logic [3:0]  read_rank_i;
  logic        cfg_we_i;
  logic [4:0]  capacity_in_use_i;
  logic        accepted_o;
  logic [3:0]  insert_rank_o;
  logic [31:0] entry_fitness_o;
  logic [15:0] entry_id_o;
  logic        rank_invalid_o;
  logic [4:0]  entry_count_o;
  logic        list_full_o;

  // Typed expectation travelling with the item, when the table gives one
  logic        pin_valid;
  outcome_t    pin_value;

  // Model state of the ranked list
  logic [31:0] rank_fit [MaxEntries];
  logic [15:0] rank_id [MaxEntries];
  int          rank_count;
  logic [4:0]  capacity_reg;

  outcome_t    pending_outcomes [$];
  int          mismatches;
  step_t       plan [PlanLen];

  top_k_ranked_list_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .result_strobe_o   (result_strobe_o),
    .operation_i       (operation_i),
    .fitness_value_i   (fitness_value_i),
    .agent_id_i        (agent_id_i),
    .read_rank_i       (read_rank_i),
    .cfg_we_i          (cfg_we_i),
    .capacity_in_use_i (capacity_in_use_i),
    .accepted_o        (accepted_o),
    .insert_rank_o     (insert_rank_o),
    .entry_fitness_o   (entry_fitness_o),
    .entry_id_o        (entry_id_o),
    .rank_invalid_o    (rank_invalid_o),
    .entry_count_o     (entry_count_o),
    .list_full_o       (list_full_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Zero and anything above the built depth map onto the legal range
  function automatic int capacity_limit();
    if (capacity_reg == 5'd0) return 1;
    if (capacity_reg > 5'(MaxEntries)) return MaxEntries;
    return int'(capacity_reg);
  endfunction

  // Apply one item to the model list and return the result it should give
  function automatic outcome_t rank_list_apply(logic [1:0] op, logic [31:0] fit,
                                               logic [15:0] id, logic [3:0] rank);
    outcome_t res;
    int       limit;
    int       pos;
    int       i;
    bit       was_full;
    res   = '0;
    limit = capacity_limit();
    case (op)
      OP_OFFER: begin
        was_full = (rank_count >= limit);
        if (!was_full || (rank_count > 0 && fit > rank_fit[rank_count-1])) begin
          // first strictly weaker entry; the weaker ones form a tail
          pos = rank_count;
          for (i = rank_count - 1; i >= 0; i--)
            if (fit > rank_fit[i]) pos = i;
          if (!was_full) rank_count++;
          for (i = rank_count - 1; i > pos; i--) begin
            rank_fit[i] = rank_fit[i-1];
            rank_id[i]  = rank_id[i-1];
          end
          rank_fit[pos]   = fit;
          rank_id[pos]    = id;
          res.accepted    = 1'b1;
          res.insert_rank = pos[3:0];
        end
      end
      OP_READ: begin
        if (int'(rank) < rank_count) begin
          res.entry_fitness = rank_fit[rank];
          res.entry_id      = rank_id[rank];
        end else begin
          res.rank_invalid = 1'b1;
        end
      end
      OP_CLEAR: rank_count = 0;
      default: ;
    endcase
    res.entry_count = rank_count[4:0];
    res.list_full   = (rank_count == limit);
    return res;
  endfunction

  // Compare each strobed result with the oldest expectation, then log new items
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    if (rst_ni) begin
      if (result_strobe_o) begin
        got = '{accepted_o, insert_rank_o, entry_fitness_o, entry_id_o,
                rank_invalid_o, entry_count_o, list_full_o};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item outstanding: cnt=%0d", $realtime,
                     got.entry_count);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.accepted !== want.accepted || got.insert_rank !== want.insert_rank ||
              got.entry_fitness !== want.entry_fitness || got.entry_id !== want.entry_id ||
              got.rank_invalid !== want.rank_invalid ||
              got.entry_count !== want.entry_count || got.list_full !== want.list_full) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected acc=%0b rank=%0d fit=%h id=%h inv=%0b cnt=%0d full=%0b",
                       $realtime, want.accepted, want.insert_rank, want.entry_fitness,
                       want.entry_id, want.rank_invalid, want.entry_count, want.list_full);
              $display("%0t:   actual acc=%0b rank=%0d fit=%h id=%h inv=%0b cnt=%0d full=%0b",
                       $realtime, got.accepted, got.insert_rank, got.entry_fitness,
                       got.entry_id, got.rank_invalid, got.entry_count, got.list_full);
            end
          end
        end
      end
      if (start && !busy) begin
        predicted = rank_list_apply(operation_i, fitness_value_i, agent_id_i, read_rank_i);
        pending_outcomes.push_back(pin_valid ? pin_value : predicted);
      end
    end
  end

  // Present one item after a gap and hold it until taken; called at a falling edge
  task automatic send(logic [1:0] op, logic [31:0] fit, logic [15:0] id, logic [3:0] rank,
                      int gap, logic pinned, outcome_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i     <= op;
    fitness_value_i <= fit;
    agent_id_i      <= id;
    read_rank_i     <= rank;
    pin_valid       <= pinned;
    pin_value       <= want;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Drain all results, then write the capacity; called at a falling edge
  task automatic settle_and_write(logic [4:0] value);
    start <= 1'b0;
    while (pending_outcomes.size() != 0 || busy) @(negedge clk_i);
    cfg_we_i          <= 1'b1;
    capacity_in_use_i <= value;
    capacity_reg = value;
    if (rank_count > capacity_limit()) rank_count = capacity_limit();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [1:0]  op;
    logic [31:0] fit;
    logic [15:0] id;
    logic [3:0]  rank;
    logic [4:0]  cap;
    int          sel;
    int          items;
    bit          burst;
    rst_ni            = 1'b0;
    start             = 1'b0;
    operation_i       = OP_OFFER;
    fitness_value_i   = '0;
    agent_id_i        = '0;
    read_rank_i       = '0;
    cfg_we_i          = 1'b0;
    capacity_in_use_i = 5'(MaxEntries);
    pin_valid         = 1'b0;
    pin_value         = '0;
    rank_count        = 0;
    capacity_reg      = 5'(MaxEntries);
    mismatches        = 0;
    foreach (rank_fit[i]) begin
      rank_fit[i] = '0;
      rank_id[i]  = '0;
    end

    // cfg_write, op, fitness, id, rank, pinned, {acc, irank, fit, id, inv, cnt, full}
    plan = '{
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd0,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 5'd0, 1'b0}},
      '{1'b0, OpUnused, 32'hFFFFFFFF, 16'hFFFF, 4'd15, 1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 5'd0, 1'b0}},
      '{1'b0, OP_OFFER, 32'hFFFFFFFF, 16'hFFFF, 4'd0,  1'b1, '{1'b1, 4'd0, 32'h0, 16'h0, 1'b0, 5'd1, 1'b0}},
      // weaker than every entry: lands at the end
      '{1'b0, OP_OFFER, 32'h0,        16'h0,    4'd0,  1'b1, '{1'b1, 4'd1, 32'h0, 16'h0, 1'b0, 5'd2, 1'b0}},
      // tie with the top entry: goes after it
      '{1'b0, OP_OFFER, 32'hFFFFFFFF, 16'h1234, 4'd0,  1'b1, '{1'b1, 4'd1, 32'h0, 16'h0, 1'b0, 5'd3, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd0,  1'b1, '{1'b0, 4'd0, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 5'd3, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd1,  1'b1, '{1'b0, 4'd0, 32'hFFFFFFFF, 16'h1234, 1'b0, 5'd3, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd2,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 5'd3, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd3,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 5'd3, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd15, 1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 5'd3, 1'b0}},
      '{1'b0, OP_OFFER, 32'h00010000, 16'hA5A5, 4'd0,  1'b0, '0},
      '{1'b0, OP_OFFER, 32'h80000000, 16'h5A5A, 4'd0,  1'b0, '0},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd2,  1'b0, '0},
      '{1'b0, OP_CLEAR, 32'h0,        16'h0,    4'd0,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 5'd0, 1'b0}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd0,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 5'd0, 1'b0}},
      // single-entry list: only a strictly better offer replaces the entry
      '{1'b1, OP_OFFER, 32'd1,        16'h0,    4'd0,  1'b0, '0},
      '{1'b0, OP_OFFER, 32'd5,        16'd1,    4'd0,  1'b1, '{1'b1, 4'd0, 32'h0, 16'h0, 1'b0, 5'd1, 1'b1}},
      '{1'b0, OP_OFFER, 32'd5,        16'd2,    4'd0,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 5'd1, 1'b1}},
      '{1'b0, OP_OFFER, 32'd6,        16'd3,    4'd0,  1'b1, '{1'b1, 4'd0, 32'h0, 16'h0, 1'b0, 5'd1, 1'b1}},
      '{1'b0, OP_OFFER, 32'd4,        16'd4,    4'd0,  1'b1, '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 5'd1, 1'b1}},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd0,  1'b1, '{1'b0, 4'd0, 32'd6, 16'd3, 1'b0, 5'd1, 1'b1}},
      // capacity zero acts as one
      '{1'b1, OP_OFFER, 32'd0,        16'h0,    4'd0,  1'b0, '0},
      '{1'b0, OP_OFFER, 32'd7,        16'd7,    4'd0,  1'b0, '0},
      '{1'b0, OP_READ,  32'h0,        16'h0,    4'd0,  1'b0, '0},
      // capacity above the depth saturates
      '{1'b1, OP_OFFER, 32'd31,       16'h0,    4'd0,  1'b0, '0},
      '{1'b0, OP_OFFER, 32'd1,        16'd9,    4'd0,  1'b0, '0},
      '{1'b0, OpUnused, 32'h12345678, 16'h4321, 4'd6,  1'b0, '0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      @(negedge clk_i);
      if (plan[i].cfg_write)
        settle_and_write(plan[i].fit[4:0]);
      else
        send(plan[i].op, plan[i].fit, plan[i].id, plan[i].rank,
             $urandom_range(0, 2), plan[i].pinned, plan[i].want);
    end

    // Random phases, each opened with a capacity write on a drained pipeline
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: cap = 5'd16;
        1: cap = 5'd1;
        2: cap = 5'd0;
        3: cap = 5'd31;
        4: cap = 5'd17;
        5: cap = 5'd2;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      @(negedge clk_i);
      settle_and_write(cap);
      burst = ($urandom_range(0, 3) == 0);
      items = $urandom_range(130, 190);
      for (int k = 0; k < items; k++) begin
        @(negedge clk_i);
        sel = $urandom_range(0, 99);
        if (sel < 60)      op = OP_OFFER;
        else if (sel < 92) op = OP_READ;
        else if (sel < 96) op = OP_CLEAR;
        else               op = OpUnused;
        // fitness: ties, full range, extremes, and values around the weakest entry
        sel = $urandom_range(0, 9);
        if (sel < 3)
          fit = 32'($urandom_range(0, 7));
        else if (sel < 6)
          fit = $urandom;
        else if (sel == 6)
          fit = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
        else if (sel < 9 && rank_count > 0)
          fit = rank_fit[rank_count-1] + 32'($urandom_range(0, 2)) - 32'd1;
        else
          fit = $urandom >> $urandom_range(0, 31);
        id = 16'($urandom);
        if (rank_count > 0 && $urandom_range(0, 3) != 0)
          rank = 4'($urandom_range(0, rank_count - 1));
        else
          rank = 4'($urandom_range(0, 15));
        send(op, fit, id, rank, burst ? 0 : $urandom_range(0, MaxGap), 1'b0, '0);
      end
    end

    // Drain and let any stray strobe show up
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tklst_pkg.sv
rtl/core/tklst_ctrl.sv
rtl/core/tklst_dpath.sv
rtl/core/top_k_ranked_list_core.sv
rtl/core/tklst_checker.sv
bench/testbench.sv
